/* hdl/goertzel_dtmf_eight_bin_core_macros.svh */
// Assertion macros for the eight-bin Goertzel core.
// They compile to nothing when SYNTHESIS is defined.
`ifndef GOERTZEL_DTMF_EIGHT_BIN_CORE_MACROS_SVH
`define GOERTZEL_DTMF_EIGHT_BIN_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define GDTMF_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define GDTMF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define GDTMF_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define GDTMF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* hdl/gdtmf_pkg.sv */
`default_nettype none
package gdtmf_pkg;
  localparam int NUM_BINS = 8;
  localparam int BIN_W    = $clog2(NUM_BINS);
  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 16;
  localparam int POWER_W  = 27;
  localparam int CNT_W    = 8;
  localparam int MUL_W    = 18;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int Q_FRAC   = 14;
  localparam int P_SHIFT  = 15;
  localparam int P_SCALE  = 8;
  localparam int ADDR_LSB = 2;
  localparam int ADDR_W   = BIN_W + ADDR_LSB;
  localparam int DATA_W   = 32;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [POWER_W-1:0]  power_t;
  typedef logic signed [MUL_W-1:0]    mul_opnd_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic [BIN_W-1:0]           bin_idx_t;

  localparam bin_idx_t BIN_LAST = BIN_W'(NUM_BINS - 1);

  typedef enum logic [2:0] {
    OP_UPD,
    OP_PCOEF,
    OP_Q1SQ,
    OP_Q2SQ,
    OP_CROSS
  } mul_op_t;

  typedef struct packed {
    logic     load_sample;
    logic     issue;
    mul_op_t  op;
    bin_idx_t bin;
    logic     out_load;
  } dp_cmd_t;
endpackage
`default_nettype wire

/* hdl/gdtmf_if.sv */
`default_nettype none
interface gdtmf_in_if;
  import gdtmf_pkg::*;
  logic    valid;
  logic    ready;
  sample_t audio_sample;
  modport source(output valid, output audio_sample, input ready);
  modport sink(input valid, input audio_sample, output ready);
endinterface

interface gdtmf_out_if;
  import gdtmf_pkg::*;
  logic   valid;
  logic   ready;
  power_t power_697hz;
  power_t power_770hz;
  power_t power_852hz;
  power_t power_941hz;
  power_t power_1209hz;
  power_t power_1336hz;
  power_t power_1477hz;
  power_t power_1633hz;
  logic   block_done;
  modport source(output valid, output power_697hz, output power_770hz, output power_852hz,
                 output power_941hz, output power_1209hz, output power_1336hz,
                 output power_1477hz, output power_1633hz, output block_done, input ready);
  modport sink(input valid, input power_697hz, input power_770hz, input power_852hz,
               input power_941hz, input power_1209hz, input power_1336hz,
               input power_1477hz, input power_1633hz, input block_done, output ready);
endinterface
`default_nettype wire

/* hdl/gdtmf_regs.sv */
`default_nettype none
module gdtmf_regs (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       psel,
  input  logic                                       penable,
  input  logic                                       pwrite,
  input  logic [gdtmf_pkg::ADDR_W-1:0]               paddr,
  input  logic [gdtmf_pkg::DATA_W-1:0]               pwdata,
  output logic [gdtmf_pkg::DATA_W-1:0]               prdata,
  output logic                                       pready,
  output gdtmf_pkg::coef_t [gdtmf_pkg::NUM_BINS-1:0] coef
);
  import gdtmf_pkg::*;

  coef_t [NUM_BINS-1:0] coef_r;
  bin_idx_t             idx;
  logic                 wr_en;

  assign idx    = paddr[ADDR_LSB +: BIN_W];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = DATA_W'($signed(coef_r[idx]));
  assign coef   = coef_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else if (wr_en) begin
      coef_r[idx] <= pwdata[COEF_W-1:0];
    end
  end
endmodule
`default_nettype wire

/* hdl/gdtmf_ctrl.sv */
`default_nettype none
module gdtmf_ctrl #(
  parameter int BLOCK_LEN = 206
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               out_ready,
  output logic               out_valid,
  output logic               out_done,
  output gdtmf_pkg::dp_cmd_t cmd
);
  import gdtmf_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_UPD   = 5'b00010,
    S_PWR   = 5'b00100,
    S_DRAIN = 5'b01000,
    S_RES   = 5'b10000
  } state_t;

  localparam logic [CNT_W-1:0] BLOCK_LAST = CNT_W'(BLOCK_LEN - 1);

  state_t             state_r, state_nxt;
  bin_idx_t           bin_r, bin_nxt;
  mul_op_t            pop_r, pop_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               done_r, done_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_done_r, out_done_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_done  = out_done_r;

  always_comb begin
    state_nxt     = state_r;
    bin_nxt       = bin_r;
    pop_nxt       = pop_r;
    count_nxt     = count_r;
    done_nxt      = done_r;
    out_valid_nxt = out_valid_r;
    out_done_nxt  = out_done_r;
    cmd           = '0;
    cmd.op        = OP_UPD;
    cmd.bin       = bin_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_sample = 1'b1;
          done_nxt        = (count_r == BLOCK_LAST);
          count_nxt       = (count_r == BLOCK_LAST) ? '0 : CNT_W'(count_r + 1'b1);
          bin_nxt         = '0;
          state_nxt       = S_UPD;
        end
      end
      S_UPD: begin
        cmd.issue = 1'b1;
        cmd.op    = OP_UPD;
        if (bin_r == BIN_LAST) begin
          bin_nxt   = '0;
          pop_nxt   = OP_PCOEF;
          state_nxt = done_r ? S_PWR : S_DRAIN;
        end else begin
          bin_nxt = BIN_W'(bin_r + 1'b1);
        end
      end
      S_PWR: begin
        cmd.issue = 1'b1;
        cmd.op    = pop_r;
        case (pop_r)
          OP_PCOEF: pop_nxt = OP_Q1SQ;
          OP_Q1SQ:  pop_nxt = OP_Q2SQ;
          OP_Q2SQ:  pop_nxt = OP_CROSS;
          default: begin
            pop_nxt = OP_PCOEF;
            if (bin_r == BIN_LAST) begin
              state_nxt = S_DRAIN;
            end else begin
              bin_nxt = BIN_W'(bin_r + 1'b1);
            end
          end
        endcase
      end
      S_DRAIN: begin
        state_nxt = S_RES;
      end
      S_RES: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          out_done_nxt  = done_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bin_r       <= '0;
      pop_r       <= OP_PCOEF;
      count_r     <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
      out_done_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bin_r       <= bin_nxt;
      pop_r       <= pop_nxt;
      count_r     <= count_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
      out_done_r  <= out_done_nxt;
    end
  end
endmodule
`default_nettype wire

/* hdl/gdtmf_dpath.sv */
`default_nettype none
module gdtmf_dpath (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  gdtmf_pkg::dp_cmd_t                          cmd,
  input  gdtmf_pkg::sample_t                          sample,
  input  gdtmf_pkg::coef_t  [gdtmf_pkg::NUM_BINS-1:0] coef,
  output gdtmf_pkg::power_t [gdtmf_pkg::NUM_BINS-1:0] power
);
  import gdtmf_pkg::*;

  sample_t                x_r;
  sample_t                q1_r [NUM_BINS];
  sample_t                q2_r [NUM_BINS];
  power_t                 held_r [NUM_BINS];
  power_t  [NUM_BINS-1:0] out_r;
  logic                   vld_r;
  mul_op_t                op_r;
  bin_idx_t               bin_r;
  prod_t                  mul_r;
  prod_t                  mul_nxt;
  mul_opnd_t              t_r;
  prod_t                  acc_r;
  mul_opnd_t              mul_a;
  mul_opnd_t              mul_b;
  sample_t                upd_t;
  sample_t                upd_q0;
  prod_t                  pwr_sum;

  assign power = out_r;

  // One shared multiplier; its operands are picked by the issued operation.
  always_comb begin
    case (cmd.op)
      OP_UPD, OP_PCOEF: begin
        mul_a = MUL_W'(q1_r[cmd.bin]);
        mul_b = MUL_W'($signed(coef[cmd.bin]));
      end
      OP_Q1SQ: begin
        mul_a = MUL_W'(q1_r[cmd.bin]);
        mul_b = MUL_W'(q1_r[cmd.bin]);
      end
      OP_Q2SQ: begin
        mul_a = MUL_W'(q2_r[cmd.bin]);
        mul_b = MUL_W'(q2_r[cmd.bin]);
      end
      OP_CROSS: begin
        mul_a = t_r;
        mul_b = MUL_W'(q2_r[cmd.bin]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_nxt = mul_a * mul_b;
  end

  assign upd_t   = mul_r[Q_FRAC +: SAMPLE_W];
  assign upd_q0  = x_r + upd_t - q2_r[bin_r];
  assign pwr_sum = acc_r - mul_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      for (int i = 0; i < NUM_BINS; i++) begin
        q1_r[i]   <= '0;
        q2_r[i]   <= '0;
        held_r[i] <= '0;
      end
    end else begin
      vld_r <= cmd.issue;
      if (vld_r && op_r == OP_UPD) begin
        q2_r[bin_r] <= q1_r[bin_r];
        q1_r[bin_r] <= upd_q0;
      end
      if (vld_r && op_r == OP_CROSS) begin
        held_r[bin_r] <= {pwr_sum[P_SHIFT +: POWER_W-P_SCALE], P_SCALE'(0)};
        q1_r[bin_r]   <= '0;
        q2_r[bin_r]   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= cmd.op;
    bin_r <= cmd.bin;
    mul_r <= mul_nxt;
    if (cmd.load_sample) begin
      x_r <= sample;
    end
    if (vld_r && op_r == OP_PCOEF) begin
      t_r <= mul_r[Q_FRAC +: MUL_W];
    end
    if (vld_r && op_r == OP_Q1SQ) begin
      acc_r <= mul_r;
    end
    if (vld_r && op_r == OP_Q2SQ) begin
      acc_r <= acc_r + mul_r;
    end
    if (cmd.out_load) begin
      for (int i = 0; i < NUM_BINS; i++) begin
        out_r[i] <= held_r[i];
      end
    end
  end
endmodule
`default_nettype wire

/* hdl/goertzel_dtmf_eight_bin_core.sv */
// A result beat follows each taken input beat through the update, drain and result states, and at
// block end through a power pass between update and drain. Only one sample is in flight at a time;
// the eight bins share one 18x18 multiplier, one product per cycle.
// A result waits in the output register while the next sample is accepted and processed.
// Synchronous active-low reset clears the delays, the held powers, the sample count and
// the coefficients; no clearing pass is needed.
`default_nettype none
`include "goertzel_dtmf_eight_bin_core_macros.svh"
module goertzel_dtmf_eight_bin_core #(
  parameter int BLOCK_LEN = 206
) (
  input  logic                           clk,
  input  logic                           rst_n,
  gdtmf_in_if.sink                       in_ch,
  gdtmf_out_if.source                    out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [gdtmf_pkg::ADDR_W-1:0]   paddr,
  input  logic [gdtmf_pkg::DATA_W-1:0]   pwdata,
  output logic [gdtmf_pkg::DATA_W-1:0]   prdata,
  output logic                           pready
);
  import gdtmf_pkg::*;

  coef_t  [NUM_BINS-1:0] coef;
  power_t [NUM_BINS-1:0] power;
  dp_cmd_t               cmd;

  gdtmf_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coef    (coef)
  );

  gdtmf_ctrl #(
    .BLOCK_LEN (BLOCK_LEN)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_done  (out_ch.block_done),
    .cmd       (cmd)
  );

  gdtmf_dpath u_dpath (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .sample (in_ch.audio_sample),
    .coef   (coef),
    .power  (power)
  );

  assign out_ch.power_697hz  = power[0];
  assign out_ch.power_770hz  = power[1];
  assign out_ch.power_852hz  = power[2];
  assign out_ch.power_941hz  = power[3];
  assign out_ch.power_1209hz = power[4];
  assign out_ch.power_1336hz = power[5];
  assign out_ch.power_1477hz = power[6];
  assign out_ch.power_1633hz = power[7];

  `GDTMF_ASSERT_NEXT(a_one_sample_at_a_time, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
  `GDTMF_ASSERT_SAME(a_no_result_overwrite, clk, rst_n, cmd.out_load, !out_ch.valid || out_ch.ready)
  `GDTMF_ASSERT_SAME(a_busy_while_issuing, clk, rst_n, cmd.issue, !in_ch.ready)
  `GDTMF_ASSERT_NEXT(a_load_shows_result, clk, rst_n, cmd.out_load, out_ch.valid)
endmodule
`default_nettype wire
